@@ sv/assert_macros.svh @@
// Assertion macros shared by the white balance RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KWB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kwb assertion failed");
`define KWB_ASSERT_NR(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("kwb assertion failed");
`else
`define KWB_ASSERT(name, clk, rst, prop)
`define KWB_ASSERT_NR(name, clk, prop)
`endif
`endif

@@ sv/kwb_pkg.sv @@
// Constants, gain tables and types for the kelvin white balance block.
package kwb_pkg;

   localparam int NUM_CH        = 3;
   localparam int CH_RED        = 0;
   localparam int CH_GREEN      = 1;
   localparam int CH_BLUE       = 2;

   localparam int NUM_POINTS    = 17;
   localparam int PT_IDX_BITS   = 5;
   localparam int SEG_BITS      = 4;
   localparam int CT_BITS       = 14;
   localparam int TAB_BITS      = 13;
   localparam int SPAN_BITS     = 10;
   localparam int DEN_BITS      = 20;
   localparam int MUL_BITS      = TAB_BITS + SPAN_BITS;
   localparam int NUM_BITS      = 22;
   localparam int GAIN_INT_BITS = 4;
   localparam int DEN_SCALE     = 1000;

   typedef logic [CT_BITS-1:0]  kelvin_type;
   typedef logic [TAB_BITS-1:0] tab_val_type;

   localparam kelvin_type KELVIN_MIN   = 14'd2000;
   localparam kelvin_type KELVIN_MAX   = 14'd10000;
   localparam kelvin_type RESET_KELVIN = 14'd5600;

   localparam kelvin_type PT_KELVIN [NUM_POINTS] = '{
      14'd2000, 14'd2500, 14'd3000, 14'd3506, 14'd4000, 14'd4503, 14'd5011, 14'd5517,
      14'd6018, 14'd6509, 14'd7040, 14'd7528, 14'd8056, 14'd8534, 14'd9032, 14'd9531,
      14'd10000};

   // gains in thousandths, one row per channel
   localparam tab_val_type PT_GAIN [NUM_CH][NUM_POINTS] = '{
      '{13'd1134, 13'd1349, 13'd1596, 13'd1731, 13'd1806, 13'd1954, 13'd2081, 13'd2197,
        13'd2291, 13'd2365, 13'd2444, 13'd2485, 13'd2528, 13'd2566, 13'd2612, 13'd2660,
        13'd2702},
      '{13'd1155, 13'd1137, 13'd1112, 13'd1056, 13'd1000, 13'd1000, 13'd1000, 13'd1000,
        13'd1000, 13'd1000, 13'd1000, 13'd1000, 13'd1000, 13'd1000, 13'd1000, 13'd1000,
        13'd1000},
      '{13'd4587, 13'd3985, 13'd3184, 13'd2524, 13'd2103, 13'd1903, 13'd1760, 13'd1641,
        13'd1542, 13'd1476, 13'd1414, 13'd1390, 13'd1363, 13'd1333, 13'd1296, 13'd1263,
        13'd1229}};

endpackage

@@ sv/kwb_ifs.sv @@
// Channel interfaces: pixel input, pixel output and temperature register write.
interface kwb_pix_in_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] red_in;
   logic [SAMPLE_BITS-1:0] green_in;
   logic [SAMPLE_BITS-1:0] blue_in;
   logic [SAMPLE_BITS-1:0] alpha_in;
   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface kwb_pix_out_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] red_out;
   logic [SAMPLE_BITS-1:0] green_out;
   logic [SAMPLE_BITS-1:0] blue_out;
   logic [SAMPLE_BITS-1:0] alpha_out;
   modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface kwb_csr_if;
   logic                         valid;
   logic                         ready;
   logic [kwb_pkg::CT_BITS-1:0]  color_temperature;
   modport source (output valid, color_temperature, input ready);
   modport sink   (input valid, color_temperature, output ready);
endinterface

@@ sv/kwb_gain_calc.sv @@
// Gain sequencer: clamp, segment search, interpolation and radix-2 division to Q4.F gains.
`include "assert_macros.svh"
module kwb_gain_calc #(
   parameter int  GAIN_FRAC_BITS = 12,
   localparam int GAIN_BITS      = GAIN_FRAC_BITS + kwb_pkg::GAIN_INT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   kwb_csr_if.sink              csr_chan,
   output logic                 gains_valid,
   output logic [GAIN_BITS-1:0] gain_out [kwb_pkg::NUM_CH]
);

   localparam int DVD_W    = kwb_pkg::NUM_BITS + GAIN_FRAC_BITS + 1;
   localparam int CNT_BITS = $clog2(GAIN_BITS);

   typedef enum logic [6:0] {
      ST_CLAMP = 7'b0000001,
      ST_SEG   = 7'b0000010,
      ST_DIFF  = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_LOAD  = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_READY = 7'b1000000
   } calc_state_type;

   calc_state_type                     state_ff, state_in;
   kwb_pkg::kelvin_type                temp_ff, temp_in;
   kwb_pkg::kelvin_type                t_ff, t_in;
   logic [kwb_pkg::SEG_BITS-1:0]       seg_ff, seg_in;
   logic [kwb_pkg::SPAN_BITS-1:0]      dk1_ff, dk1_in, dk0_ff, dk0_in;
   logic [kwb_pkg::DEN_BITS-1:0]       den_ff, den_in;
   kwb_pkg::tab_val_type               g0_ff [kwb_pkg::NUM_CH];
   kwb_pkg::tab_val_type               g0_in [kwb_pkg::NUM_CH];
   kwb_pkg::tab_val_type               g1_ff [kwb_pkg::NUM_CH];
   kwb_pkg::tab_val_type               g1_in [kwb_pkg::NUM_CH];
   logic [kwb_pkg::NUM_BITS-1:0]       num_ff [kwb_pkg::NUM_CH];
   logic [kwb_pkg::NUM_BITS-1:0]       num_in [kwb_pkg::NUM_CH];
   logic [kwb_pkg::DEN_BITS-1:0]       rem_ff [kwb_pkg::NUM_CH];
   logic [kwb_pkg::DEN_BITS-1:0]       rem_in [kwb_pkg::NUM_CH];
   logic [GAIN_BITS-1:0]               dvd_ff [kwb_pkg::NUM_CH];
   logic [GAIN_BITS-1:0]               dvd_in [kwb_pkg::NUM_CH];
   logic [GAIN_BITS-1:0]               gain_ff [kwb_pkg::NUM_CH];
   logic [GAIN_BITS-1:0]               gain_in [kwb_pkg::NUM_CH];
   logic [CNT_BITS-1:0]                cnt_ff, cnt_in;
   logic                               csr_acc;

   assign csr_chan.ready = (state_ff == ST_READY);
   assign gains_valid    = (state_ff == ST_READY);
   assign csr_acc        = csr_chan.valid && csr_chan.ready;

   always_comb begin
      logic [kwb_pkg::PT_IDX_BITS-1:0] lo_idx;
      logic [kwb_pkg::PT_IDX_BITS-1:0] hi_idx;
      logic [kwb_pkg::SEG_BITS-1:0]    seg_tmp;
      logic [kwb_pkg::MUL_BITS-1:0]    prod0;
      logic [kwb_pkg::MUL_BITS-1:0]    prod1;
      logic [kwb_pkg::MUL_BITS:0]      psum;
      logic [DVD_W-1:0]                dvd_full;
      logic [kwb_pkg::DEN_BITS:0]      rem_sh;
      logic                            ge;

      state_in = state_ff;
      temp_in  = temp_ff;
      t_in     = t_ff;
      seg_in   = seg_ff;
      dk1_in   = dk1_ff;
      dk0_in   = dk0_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      lo_idx   = kwb_pkg::PT_IDX_BITS'(seg_ff);
      hi_idx   = lo_idx + kwb_pkg::PT_IDX_BITS'(1);
      seg_tmp  = '0;
      prod0    = '0;
      prod1    = '0;
      psum     = '0;
      dvd_full = '0;
      rem_sh   = '0;
      ge       = 1'b0;
      for (int c = 0; c < kwb_pkg::NUM_CH; c++) begin
         g0_in[c]   = g0_ff[c];
         g1_in[c]   = g1_ff[c];
         num_in[c]  = num_ff[c];
         rem_in[c]  = rem_ff[c];
         dvd_in[c]  = dvd_ff[c];
         gain_in[c] = gain_ff[c];
      end

      unique case (state_ff)
         ST_CLAMP: begin
            if (temp_ff < kwb_pkg::KELVIN_MIN) begin
               t_in = kwb_pkg::KELVIN_MIN;
            end else if (temp_ff > kwb_pkg::KELVIN_MAX) begin
               t_in = kwb_pkg::KELVIN_MAX;
            end else begin
               t_in = temp_ff;
            end
            state_in = ST_SEG;
         end
         ST_SEG: begin
            for (int i = 1; i < kwb_pkg::NUM_POINTS - 1; i++) begin
               if (t_ff > kwb_pkg::PT_KELVIN[i]) begin
                  seg_tmp = kwb_pkg::SEG_BITS'(i);
               end
            end
            seg_in   = seg_tmp;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dk1_in = kwb_pkg::SPAN_BITS'(kwb_pkg::PT_KELVIN[hi_idx] - t_ff);
            dk0_in = kwb_pkg::SPAN_BITS'(t_ff - kwb_pkg::PT_KELVIN[lo_idx]);
            den_in = kwb_pkg::DEN_BITS'(kwb_pkg::DEN_SCALE *
                     int'(kwb_pkg::PT_KELVIN[hi_idx] - kwb_pkg::PT_KELVIN[lo_idx]));
            for (int c = 0; c < kwb_pkg::NUM_CH; c++) begin
               g0_in[c] = kwb_pkg::PT_GAIN[c][lo_idx];
               g1_in[c] = kwb_pkg::PT_GAIN[c][hi_idx];
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            for (int c = 0; c < kwb_pkg::NUM_CH; c++) begin
               prod0 = kwb_pkg::MUL_BITS'(g0_ff[c]) * kwb_pkg::MUL_BITS'(dk1_ff);
               prod1 = kwb_pkg::MUL_BITS'(g1_ff[c]) * kwb_pkg::MUL_BITS'(dk0_ff);
               psum  = (kwb_pkg::MUL_BITS+1)'(prod0) + (kwb_pkg::MUL_BITS+1)'(prod1);
               num_in[c] = kwb_pkg::NUM_BITS'(psum);
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            for (int c = 0; c < kwb_pkg::NUM_CH; c++) begin
               dvd_full  = {1'b0, num_ff[c], GAIN_FRAC_BITS'(0)} + DVD_W'(den_ff >> 1);
               rem_in[c] = kwb_pkg::DEN_BITS'(dvd_full[DVD_W-1:GAIN_BITS]);
               dvd_in[c] = dvd_full[GAIN_BITS-1:0];
            end
            cnt_in   = CNT_BITS'(GAIN_BITS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            for (int c = 0; c < kwb_pkg::NUM_CH; c++) begin
               rem_sh    = {rem_ff[c], dvd_ff[c][GAIN_BITS-1]};
               ge        = (rem_sh >= {1'b0, den_ff});
               rem_in[c] = ge ? kwb_pkg::DEN_BITS'(rem_sh - {1'b0, den_ff})
                              : kwb_pkg::DEN_BITS'(rem_sh);
               dvd_in[c] = {dvd_ff[c][GAIN_BITS-2:0], ge};
               if (cnt_ff == '0) begin
                  gain_in[c] = dvd_in[c];
               end
            end
            if (cnt_ff == '0) begin
               state_in = ST_READY;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         ST_READY: begin
            if (csr_acc) begin
               temp_in  = csr_chan.color_temperature;
               state_in = ST_CLAMP;
            end
         end
         default: begin
            state_in = ST_CLAMP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLAMP;
         temp_ff  <= kwb_pkg::RESET_KELVIN;
      end else begin
         state_ff <= state_in;
         temp_ff  <= temp_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      seg_ff <= seg_in;
      dk1_ff <= dk1_in;
      dk0_ff <= dk0_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      for (int c = 0; c < kwb_pkg::NUM_CH; c++) begin
         g0_ff[c]   <= g0_in[c];
         g1_ff[c]   <= g1_in[c];
         num_ff[c]  <= num_in[c];
         rem_ff[c]  <= rem_in[c];
         dvd_ff[c]  <= dvd_in[c];
         gain_ff[c] <= gain_in[c];
      end
   end

   assign gain_out = gain_ff;

   `KWB_ASSERT_NR(a_reset_recalc, clock, reset |=> !gains_valid)
   `KWB_ASSERT(a_cfg_restarts, clock, reset, csr_acc |=> !gains_valid)
   `KWB_ASSERT(a_div_ends, clock, reset, (state_ff == ST_DIV && cnt_ff == '0) |=> gains_valid)
   `KWB_ASSERT(a_green_unity, clock, reset, gains_valid |-> (gain_ff[kwb_pkg::CH_GREEN] >= (GAIN_BITS'(1) << GAIN_FRAC_BITS)))

endmodule

@@ sv/kwb_pixel_pipe.sv @@
// Three-stage pixel datapath: register, multiply by gain, round and saturate.
`include "assert_macros.svh"
module kwb_pixel_pipe #(
   parameter int  SAMPLE_BITS    = 16,
   parameter int  GAIN_FRAC_BITS = 12,
   localparam int GAIN_BITS      = GAIN_FRAC_BITS + kwb_pkg::GAIN_INT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 gains_valid,
   input  logic [GAIN_BITS-1:0] gain_in [kwb_pkg::NUM_CH],
   kwb_pix_in_if.sink           req_chan,
   kwb_pix_out_if.source        rsp_chan
);

   localparam int PROD_W = SAMPLE_BITS + GAIN_BITS;
   localparam int SHR_W  = PROD_W + 1 - GAIN_FRAC_BITS;

   logic [SAMPLE_BITS-1:0] smp_in [kwb_pkg::NUM_CH];
   logic [SAMPLE_BITS-1:0] s1_ff  [kwb_pkg::NUM_CH];
   logic [PROD_W-1:0]      p2_ff  [kwb_pkg::NUM_CH];
   logic [PROD_W-1:0]      p2_in  [kwb_pkg::NUM_CH];
   logic [SAMPLE_BITS-1:0] o3_ff  [kwb_pkg::NUM_CH];
   logic [SAMPLE_BITS-1:0] o3_in  [kwb_pkg::NUM_CH];
   logic [SAMPLE_BITS-1:0] a1_ff, a2_ff, a3_ff;
   logic                   v1_ff, v2_ff, v3_ff;
   logic                   v1_in;
   logic                   rdy1, rdy2, rdy3;

   assign smp_in[kwb_pkg::CH_RED]   = req_chan.red_in;
   assign smp_in[kwb_pkg::CH_GREEN] = req_chan.green_in;
   assign smp_in[kwb_pkg::CH_BLUE]  = req_chan.blue_in;

   assign rdy3 = !v3_ff || rsp_chan.ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_chan.ready = rdy1 && gains_valid;
   assign v1_in          = req_chan.valid && req_chan.ready;

   always_comb begin
      logic [PROD_W:0]  rnd;
      logic [SHR_W-1:0] shr;
      for (int c = 0; c < kwb_pkg::NUM_CH; c++) begin
         p2_in[c] = PROD_W'(s1_ff[c]) * PROD_W'(gain_in[c]);
         rnd      = (PROD_W+1)'(p2_ff[c]) + ((PROD_W+1)'(1) << (GAIN_FRAC_BITS - 1));
         shr      = rnd[PROD_W:GAIN_FRAC_BITS];
         o3_in[c] = (|shr[SHR_W-1:SAMPLE_BITS]) ? '1 : shr[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= v1_in;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= smp_in;
         a1_ff <= req_chan.alpha_in;
      end
      if (rdy2) begin
         p2_ff <= p2_in;
         a2_ff <= a1_ff;
      end
      if (rdy3) begin
         o3_ff <= o3_in;
         a3_ff <= a2_ff;
      end
   end

   assign rsp_chan.valid     = v3_ff;
   assign rsp_chan.red_out   = o3_ff[kwb_pkg::CH_RED];
   assign rsp_chan.green_out = o3_ff[kwb_pkg::CH_GREEN];
   assign rsp_chan.blue_out  = o3_ff[kwb_pkg::CH_BLUE];
   assign rsp_chan.alpha_out = a3_ff;

   `KWB_ASSERT(a_accept_needs_gains, clock, reset, (req_chan.valid && req_chan.ready) |-> gains_valid)
   `KWB_ASSERT(a_mid_stall_holds, clock, reset, (v2_ff && !rdy3) |=> (v2_ff && $stable(a2_ff)))
   `KWB_ASSERT(a_alpha_moves, clock, reset, (v2_ff && rdy3) |=> (v3_ff && a3_ff == $past(a2_ff)))

endmodule

@@ sv/kelvin_white_balance_top.sv @@
// Kelvin white balance top level: temperature-driven RGB gains applied per pixel.
// The block takes one RGBA pixel per clock while gains are valid and the output is not
// stalled, and returns it via input, product and output registers with red, green and
// blue scaled by Q4.F gains, rounded and saturated; alpha is copied. Gains come from the
// color temperature register (clamped to 2000..10000 K), interpolated on a fixed 17-point
// table by a sequencer whose divider yields one quotient bit per cycle: after reset and
// every register write it recomputes them, while req_chan.ready and csr_chan.ready stay low.
// Write the register only when no transaction is in flight.
module kelvin_white_balance_top #(
   parameter int SAMPLE_BITS    = 16,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic          clock,
   input  logic          reset,
   kwb_pix_in_if.sink    req_chan,
   kwb_pix_out_if.source rsp_chan,
   kwb_csr_if.sink       csr_chan
);

   localparam int GAIN_BITS = GAIN_FRAC_BITS + kwb_pkg::GAIN_INT_BITS;

   logic                 gains_valid;
   logic [GAIN_BITS-1:0] gain [kwb_pkg::NUM_CH];

   kwb_gain_calc #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_gain_calc (
      .clock       (clock),
      .reset       (reset),
      .csr_chan    (csr_chan),
      .gains_valid (gains_valid),
      .gain_out    (gain)
   );

   kwb_pixel_pipe #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_pixel_pipe (
      .clock       (clock),
      .reset       (reset),
      .gains_valid (gains_valid),
      .gain_in     (gain),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

endmodule
